### hw/rtl/jlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint limit repulsion package
// Shared widths, register codes, configuration type and saturation helper.
// ----------------------------------------------------------------------------
package jlr_pkg;

    localparam int JOINT_W      = 3;
    localparam int DATA_W       = 32;
    localparam int DIST_W       = 31;
    localparam int ACT_W        = 17;
    localparam int TERM_W       = 50;
    localparam int APB_ADDR_W   = 4;
    localparam int N_JOINTS_DEF = 8;
    localparam int LANE_STAGES  = 7;

    localparam int ONE_INT = 65536;
    localparam logic [ACT_W-1:0] ONE_Q16   = ACT_W'(ONE_INT);
    localparam logic [ACT_W:0]   SMOOTH_K  = (ACT_W + 1)'(3 * ONE_INT);

    localparam logic [1:0] REG_ACT_DIST  = 2'd0;
    localparam logic [1:0] REG_INV_DIST  = 2'd1;
    localparam logic [1:0] REG_PUSH_GAIN = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic [DIST_W-1:0] ACT_DIST_RST  = DIST_W'(6554);
    localparam logic [DATA_W-1:0] INV_DIST_RST  = DATA_W'(655360);
    localparam logic [DATA_W-1:0] PUSH_GAIN_RST = DATA_W'(65536);

    typedef struct packed {
        logic [DIST_W-1:0] act_dist;
        logic [DATA_W-1:0] inv_dist;
        logic [DATA_W-1:0] push_gain;
    } jlr_cfg_t;

    typedef struct packed {
        logic               hit;
        logic [32:0]        depth;
        logic signed [32:0] diff;
    } jlr_band_t;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/jlr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module jlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/jlr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file for band width, its reciprocal and the push gain.
// ----------------------------------------------------------------------------
module jlr_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [jlr_pkg::DATA_W-1:0]      pwdata,
    output logic [jlr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output jlr_pkg::jlr_cfg_t               cfg
);
    import jlr_pkg::*;

    logic [DIST_W-1:0] act_dist_reg;
    logic [DATA_W-1:0] inv_dist_reg;
    logic [DATA_W-1:0] push_gain_reg;
    logic [1:0]        reg_idx;
    logic              wr_stb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_stb  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_dist_reg  <= ACT_DIST_RST;
            inv_dist_reg  <= INV_DIST_RST;
            push_gain_reg <= PUSH_GAIN_RST;
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_ACT_DIST:  act_dist_reg  <= pwdata[DIST_W-1:0];
                REG_INV_DIST:  inv_dist_reg  <= pwdata;
                REG_PUSH_GAIN: push_gain_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ACT_DIST:  prdata = DATA_W'(act_dist_reg);
            REG_INV_DIST:  prdata = inv_dist_reg;
            REG_PUSH_GAIN: prdata = push_gain_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.act_dist  = act_dist_reg;
    assign cfg.inv_dist  = inv_dist_reg;
    assign cfg.push_gain = push_gain_reg;

endmodule

### hw/rtl/jlr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repulsion band lane
// Seven-stage multiplier chain: normalized distance, smoothstep, gain and
// push term for one side of the joint.
// ----------------------------------------------------------------------------
module jlr_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  jlr_pkg::jlr_cfg_t                 cfg,
    input  jlr_pkg::jlr_band_t                band,
    output logic [jlr_pkg::ACT_W-1:0]         act,
    output logic signed [jlr_pkg::TERM_W-1:0] term
);
    import jlr_pkg::*;

    logic               hit1_reg, hit2_reg, hit3_reg;
    logic [32:0]        depth1_reg;
    logic signed [32:0] diff1_reg, diff2_reg, diff3_reg, diff4_reg;
    logic               ge2_reg;
    logic [62:0]        ratio2_reg;
    logic [32:0]        sq3_reg;
    logic [ACT_W:0]     wt3_reg;
    logic [ACT_W-1:0]   act4_reg, act5_reg, act6_reg, act7_reg;
    logic [DATA_W-1:0]  gain5_reg, mag5_reg;
    logic               neg5_reg, neg6_reg;
    logic [47:0]        hi6_reg, lo6_reg;
    logic signed [TERM_W-1:0] term7_reg;

    logic [ACT_W-1:0]   t_sel;
    logic [50:0]        smooth;
    logic [48:0]        gain_prod;
    logic signed [32:0] diff_abs;
    logic [48:0]        mag_sum;

    always_comb begin
        if (ge2_reg) begin
            t_sel = ONE_Q16;
        end else if (ratio2_reg[62:16] > 47'(ONE_INT)) begin
            t_sel = ONE_Q16;
        end else begin
            t_sel = ratio2_reg[32:16];
        end
    end

    assign smooth    = 51'(sq3_reg) * 51'(wt3_reg);
    assign gain_prod = 49'(cfg.push_gain) * 49'(act4_reg);
    assign diff_abs  = diff4_reg[32] ? -diff4_reg : diff4_reg;
    assign mag_sum   = 49'(hi6_reg) + 49'(lo6_reg[47:16]);

    always_ff @(posedge aclk) begin
        if (en) begin
            hit1_reg   <= band.hit;
            depth1_reg <= band.depth;
            diff1_reg  <= band.diff;

            hit2_reg   <= hit1_reg;
            ge2_reg    <= depth1_reg >= 33'(cfg.act_dist);
            ratio2_reg <= 63'(depth1_reg[DIST_W-1:0]) * 63'(cfg.inv_dist);
            diff2_reg  <= diff1_reg;

            hit3_reg   <= hit2_reg;
            sq3_reg    <= 33'(t_sel) * 33'(t_sel);
            wt3_reg    <= SMOOTH_K - {t_sel, 1'b0};
            diff3_reg  <= diff2_reg;

            act4_reg   <= hit3_reg ? smooth[48:32] : '0;
            diff4_reg  <= diff3_reg;

            gain5_reg  <= gain_prod[47:16];
            act5_reg   <= act4_reg;
            mag5_reg   <= diff_abs[31:0];
            neg5_reg   <= diff4_reg[32];

            hi6_reg    <= 48'(gain5_reg) * 48'(mag5_reg[31:16]);
            lo6_reg    <= 48'(gain5_reg) * 48'(mag5_reg[15:0]);
            neg6_reg   <= neg5_reg;
            act6_reg   <= act5_reg;

            term7_reg  <= neg6_reg ? -$signed({1'b0, mag_sum}) : $signed({1'b0, mag_sum});
            act7_reg   <= act6_reg;
        end
    end

    assign act  = act7_reg;
    assign term = term7_reg;

endmodule

### hw/rtl/joint_limit_repulsion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint limit repulsion core
// Stores per-joint inner edges and turns joint positions into a saturated
// smoothstep repulsion push and the larger side activation.
//
//   Channel   Signals                      Item
//   s_        tvalid tready tdata tuser    load limits or evaluate position
//   m_        tvalid tready tdata          joint, push, activation
//   APB       psel penable pwrite paddr    band width, reciprocal, gain
//
// One item per cycle while m_ is not stalled; an evaluate item passes through
// the registered edge RAM read, the lane multiplier chain and the output
// register before it shows on m_.
// Load items with an in-range joint write both edge RAMs at accept.
// Reset is synchronous; the edge RAMs are not cleared.
// A held result stalls the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
module joint_limit_repulsion_core #(
    parameter int N_JOINTS = jlr_pkg::N_JOINTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // joint_index, joint_position, limit_min, limit_max, limit_margin, zeros
    input  logic [135:0]                   s_tdata,
    // kind
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_joint, push_res, activation, zeros
    output logic [55:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jlr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jlr_pkg::DATA_W-1:0]     pwdata,
    output logic [jlr_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import jlr_pkg::*;

    localparam int AW = (N_JOINTS > 1) ? $clog2(N_JOINTS) : 1;

    jlr_cfg_t cfg;

    logic                     in_kind;
    logic [JOINT_W-1:0]       in_joint;
    logic signed [DATA_W-1:0] in_pos, in_min, in_max;
    logic [DIST_W-1:0]        in_margin;
    logic [JOINT_W+AW-1:0]    joint_ext;
    logic [AW-1:0]            joint_addr;
    logic                     in_range;
    logic                     adv, s_acc, load_wr;
    logic [DATA_W-1:0]        edge_lo_wr, edge_hi_wr;

    logic                     vld0_reg, inr0_reg;
    logic [JOINT_W-1:0]       joint0_reg;
    logic signed [DATA_W-1:0] q0_reg;
    logic signed [DATA_W-1:0] lo_rd, hi_rd;

    logic [LANE_STAGES-1:0]              vld_pipe_reg, inr_pipe_reg;
    logic [LANE_STAGES-1:0][JOINT_W-1:0] joint_pipe_reg;

    logic signed [32:0] diff_lo, diff_hi;
    logic signed [34:0] depth_lo, depth_hi;
    jlr_band_t          band_lo, band_hi;

    logic [ACT_W-1:0]          act_lo, act_hi;
    logic signed [TERM_W-1:0]  term_lo, term_hi;
    logic signed [TERM_W:0]    push_sum;

    logic                m_tvalid_reg;
    logic [JOINT_W-1:0]  out_joint_reg;
    logic [DATA_W-1:0]   out_push_reg;
    logic [ACT_W-1:0]    out_act_reg;

    assign in_kind    = s_tuser[0];
    assign in_joint   = s_tdata[2:0];
    assign in_pos     = s_tdata[34:3];
    assign in_min     = s_tdata[66:35];
    assign in_max     = s_tdata[98:67];
    assign in_margin  = s_tdata[129:99];
    assign joint_ext  = (JOINT_W + AW)'(in_joint);
    assign joint_addr = joint_ext[AW-1:0];
    assign in_range   = 32'(in_joint) < 32'(N_JOINTS);

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign s_acc    = s_tvalid && s_tready;
    assign load_wr  = s_acc && (in_kind == KIND_LOAD) && in_range;

    assign edge_lo_wr = sat32(64'(in_min) + 64'(in_margin));
    assign edge_hi_wr = sat32(64'(in_max) - 64'(in_margin));

    jlr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jlr_ram #(.WIDTH(DATA_W), .DEPTH(N_JOINTS)) u_lo_ram (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (joint_addr),
        .wr_data (edge_lo_wr),
        .rd_en   (adv),
        .rd_addr (joint_addr),
        .rd_data (lo_rd)
    );

    jlr_ram #(.WIDTH(DATA_W), .DEPTH(N_JOINTS)) u_hi_ram (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (joint_addr),
        .wr_data (edge_hi_wr),
        .rd_en   (adv),
        .rd_addr (joint_addr),
        .rd_data (hi_rd)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            joint0_reg <= in_joint;
            inr0_reg   <= in_range;
            q0_reg     <= in_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (adv) begin
            vld0_reg <= s_acc && (in_kind == KIND_EVAL);
        end
    end

    assign diff_lo  = 33'(lo_rd) - 33'(q0_reg);
    assign diff_hi  = 33'(hi_rd) - 33'(q0_reg);
    assign depth_lo = 35'(diff_lo) + 35'(cfg.act_dist);
    assign depth_hi = 35'(cfg.act_dist) - 35'(diff_hi);

    assign band_lo.hit   = depth_lo > 0;
    assign band_lo.depth = depth_lo[32:0];
    assign band_lo.diff  = diff_lo;
    assign band_hi.hit   = depth_hi > 0;
    assign band_hi.depth = depth_hi[32:0];
    assign band_hi.diff  = diff_hi;

    jlr_lane u_lane_lo (
        .aclk (aclk),
        .en   (adv),
        .cfg  (cfg),
        .band (band_lo),
        .act  (act_lo),
        .term (term_lo)
    );

    jlr_lane u_lane_hi (
        .aclk (aclk),
        .en   (adv),
        .cfg  (cfg),
        .band (band_hi),
        .act  (act_hi),
        .term (term_hi)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            joint_pipe_reg[0] <= joint0_reg;
            inr_pipe_reg[0]   <= inr0_reg;
            for (int i = 1; i < LANE_STAGES; i++) begin
                joint_pipe_reg[i] <= joint_pipe_reg[i-1];
                inr_pipe_reg[i]   <= inr_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_pipe_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_pipe_reg <= {vld_pipe_reg[LANE_STAGES-2:0], vld0_reg};
            m_tvalid_reg <= vld_pipe_reg[LANE_STAGES-1];
        end
    end

    assign push_sum = (TERM_W + 1)'(term_lo) + (TERM_W + 1)'(term_hi);

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_joint_reg <= joint_pipe_reg[LANE_STAGES-1];
            if (inr_pipe_reg[LANE_STAGES-1]) begin
                out_push_reg <= sat32(64'(push_sum));
                out_act_reg  <= (act_lo > act_hi) ? act_lo : act_hi;
            end else begin
                out_push_reg <= '0;
                out_act_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_act_reg, out_push_reg, out_joint_reg};

endmodule

### hw/rtl/jlr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint limit repulsion checker
// Port-level assertions on reset, output hold, result ranges, push without activation and input readiness.
// ----------------------------------------------------------------------------
module jlr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [55:0]                    m_tdata
);
    import jlr_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid not cleared by reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    a_act_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[51:35] <= ONE_Q16)
        else $error("activation above one");

    a_no_act_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[51:35] == '0) |-> m_tdata[34:3] == '0)
        else $error("push without activation");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind joint_limit_repulsion_core jlr_checker u_jlr_checker (.*);
